// File: hw/rtl/dts_pkg.sv
`default_nettype none

package dts_pkg;

  // Default sizing
  localparam int DTS_CHANNELS      = 8;
  localparam int DTS_HIHAT_CHANNEL = 6;

  // Field widths
  localparam int DTS_TIME_W   = 32;
  localparam int DTS_PW_W     = 16;
  localparam int DTS_CHAN_W   = 3;
  localparam int DTS_MASK_W   = 8;
  localparam int DTS_CMD_W    = 2;
  localparam int DTS_BEAT_W   = 30;
  localparam int DTS_DIV_W    = 8;
  localparam int DTS_ADDR_W   = 3;
  localparam int DTS_IN_DATA_W  = 48;
  localparam int DTS_OUT_DATA_W = 48;

  // Reset values
  localparam logic [DTS_TIME_W-1:0] DTS_ALL_ONES     = '1;
  localparam logic [DTS_TIME_W-1:0] DTS_LED_START    = 32'd10;
  localparam logic [DTS_TIME_W-1:0] DTS_STEP_DEFAULT = 32'd250;
  localparam logic [DTS_BEAT_W-1:0] DTS_BEAT_DEFAULT = 30'd250;
  localparam logic [DTS_PW_W-1:0]   DTS_FLASH_DEFAULT = 16'd70;
  localparam logic [DTS_DIV_W-1:0]  DTS_POLL_DEFAULT    = 8'd60;
  localparam logic [DTS_DIV_W-1:0]  DTS_REFRESH_DEFAULT = 8'd200;
  localparam logic [DTS_PW_W-1:0]   DTS_PW_MAX = '1;

  // Command codes
  localparam logic [DTS_CMD_W-1:0] CMD_TICK = 2'd0;
  localparam logic [DTS_CMD_W-1:0] CMD_LOAD = 2'd1;
  localparam logic [DTS_CMD_W-1:0] CMD_ARM  = 2'd2;

  // Register indexes
  localparam logic [DTS_ADDR_W-1:0] REG_STEP_PERIOD    = 3'd0;
  localparam logic [DTS_ADDR_W-1:0] REG_BEAT_PERIOD    = 3'd1;
  localparam logic [DTS_ADDR_W-1:0] REG_FLASH_LENGTH   = 3'd2;
  localparam logic [DTS_ADDR_W-1:0] REG_POLL_PERIOD    = 3'd3;
  localparam logic [DTS_ADDR_W-1:0] REG_REFRESH_PERIOD = 3'd4;

  // Per-item control handed to every channel
  typedef struct packed {
    logic                  tick;
    logic                  step_hit;
    logic                  hold;
    logic                  load;
    logic [DTS_CHAN_W-1:0] load_chan;
    logic [DTS_PW_W-1:0]   load_pw;
    logic [DTS_TIME_W-1:0] tick_n;
  } dts_chan_ctl_t;

endpackage

`default_nettype wire

// File: hw/rtl/drum_trigger_tick_scheduler.sv
// A beat accepted into the input register moves on into the result register as a result beat.
// Throughput: one beat per cycle if unstalled; all channel comparators and adders work in parallel.
// A stalled output holds one result while one more beat waits in the input register.
// Reset (rst_n, synchronous, active low) restores every control and state register at once,
// with no clearing pass; the block is ready for beats as soon as reset is released.
`default_nettype none

module drum_trigger_tick_scheduler
  import dts_pkg::*;
#(
  parameter int CHANNELS      = DTS_CHANNELS,
  parameter int HIHAT_CHANNEL = DTS_HIHAT_CHANNEL
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  // Input stream
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  // [2:0] channel, [34:3] value, [42:35] step_mask, [43] hihat_hold, [47:44] zero
  input  wire logic [DTS_IN_DATA_W-1:0]  in_tdata,
  // [1:0] cmd
  input  wire logic [DTS_CMD_W-1:0]      in_tuser,
  // Result stream
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  // [7:0] trigger_active, [8] led_lit, [9] step_fired, [10] poll_due,
  // [11] refresh_due, [43:12] tick_now, [47:44] zero
  output logic [DTS_OUT_DATA_W-1:0]      out_tdata,
  // Configuration
  input  wire logic                      cfg_we,
  input  wire logic [DTS_ADDR_W-1:0]     cfg_addr,
  input  wire logic [DTS_TIME_W-1:0]     cfg_wdata
);

  localparam int NCH = (CHANNELS < DTS_MASK_W) ? CHANNELS : DTS_MASK_W;

  // Configuration registers
  logic [DTS_TIME_W-1:0] step_period_r;
  logic [DTS_BEAT_W-1:0] beat_period_r;
  logic [DTS_PW_W-1:0]   flash_length_r;
  logic [DTS_DIV_W-1:0]  poll_period_r;
  logic [DTS_DIV_W-1:0]  refresh_period_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_period_r    <= DTS_STEP_DEFAULT;
      beat_period_r    <= DTS_BEAT_DEFAULT;
      flash_length_r   <= DTS_FLASH_DEFAULT;
      poll_period_r    <= DTS_POLL_DEFAULT;
      refresh_period_r <= DTS_REFRESH_DEFAULT;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_STEP_PERIOD:    step_period_r    <= cfg_wdata;
        REG_BEAT_PERIOD:    beat_period_r    <= cfg_wdata[DTS_BEAT_W-1:0];
        REG_FLASH_LENGTH:   flash_length_r   <= cfg_wdata[DTS_PW_W-1:0];
        REG_POLL_PERIOD:    poll_period_r    <= cfg_wdata[DTS_DIV_W-1:0];
        REG_REFRESH_PERIOD: refresh_period_r <= cfg_wdata[DTS_DIV_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  logic                  s1_valid_r;
  logic [DTS_CMD_W-1:0]  s1_cmd_r;
  logic [DTS_CHAN_W-1:0] s1_channel_r;
  logic [DTS_TIME_W-1:0] s1_value_r;
  logic [DTS_MASK_W-1:0] s1_mask_r;
  logic                  s1_hold_r;
  logic                  out_valid_r;
  logic [DTS_OUT_DATA_W-1:0] out_data_r;
  logic                  go;

  assign go        = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_cmd_r     <= in_tuser;
      s1_channel_r <= in_tdata[2:0];
      s1_value_r   <= in_tdata[34:3];
      s1_mask_r    <= in_tdata[42:35];
      s1_hold_r    <= in_tdata[43];
    end
  end

  // Scheduler state
  logic [DTS_TIME_W-1:0] tick_count_r;
  logic [DTS_TIME_W-1:0] tick_inc_r;
  logic [DTS_TIME_W-1:0] next_step_r;
  logic [DTS_TIME_W-1:0] led_on_r;
  logic [DTS_TIME_W-1:0] led_off_r;
  logic                  led_r;
  logic [DTS_TIME_W-1:0] tick_count_nxt;
  logic [DTS_TIME_W-1:0] tick_inc_nxt;
  logic [DTS_TIME_W-1:0] next_step_nxt;
  logic [DTS_TIME_W-1:0] led_on_nxt;
  logic [DTS_TIME_W-1:0] led_off_nxt;
  logic                  led_nxt;

  logic                  is_tick;
  logic                  is_load;
  logic                  is_arm;
  logic                  step_hit;
  logic                  led_on_hit;
  logic                  led_off_hit;
  logic [DTS_TIME_W:0]   off_sum;
  logic [DTS_TIME_W-1:0] tick_n;
  logic [DTS_PW_W-1:0]   pw_sat;
  dts_chan_ctl_t         chan_ctl;

  always_comb begin
    is_tick = 1'b0;
    is_load = 1'b0;
    is_arm  = 1'b0;
    unique case (s1_cmd_r)
      CMD_TICK: is_tick = go;
      CMD_LOAD: is_load = go;
      CMD_ARM:  is_arm  = go;
      default: ;
    endcase
  end

  // The incremented count is kept ready in its own register
  assign tick_n = tick_inc_r;
  assign pw_sat = (|s1_value_r[DTS_TIME_W-1:DTS_PW_W]) ? DTS_PW_MAX
                                                       : s1_value_r[DTS_PW_W-1:0];

  always_comb begin
    tick_count_nxt = tick_count_r;
    tick_inc_nxt   = tick_inc_r;
    next_step_nxt  = next_step_r;
    led_on_nxt     = led_on_r;
    led_off_nxt    = led_off_r;
    led_nxt        = led_r;
    step_hit       = 1'b0;
    led_on_hit     = 1'b0;
    led_off_hit    = 1'b0;
    off_sum        = {1'b0, tick_n} + {{(DTS_TIME_W + 1 - DTS_PW_W){1'b0}}, flash_length_r};

    if (is_tick) begin
      tick_count_nxt = tick_n;
      tick_inc_nxt   = tick_n + 1'b1;

      // Metronome LED: a fresh off time is due now only if it wrapped or the flash length is zero
      led_on_hit = (tick_n >= led_on_r);
      if (led_on_hit) begin
        led_nxt     = 1'b1;
        led_off_nxt = off_sum[DTS_TIME_W-1:0];
        led_on_nxt  = tick_n + {beat_period_r, 2'b00};
        led_off_hit = off_sum[DTS_TIME_W] || (flash_length_r == '0);
      end else begin
        led_off_hit = (tick_n >= led_off_r);
      end
      if (led_off_hit) begin
        led_nxt     = 1'b0;
        led_off_nxt = DTS_ALL_ONES;
      end

      // Sequencer step
      step_hit = (tick_n >= next_step_r);
      if (step_hit) begin
        next_step_nxt = next_step_r + step_period_r;
      end
    end else if (is_arm) begin
      next_step_nxt = s1_value_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_count_r <= '0;
      tick_inc_r   <= {{(DTS_TIME_W - 1){1'b0}}, 1'b1};
      next_step_r  <= DTS_ALL_ONES;
      led_on_r     <= DTS_LED_START;
      led_off_r    <= DTS_ALL_ONES;
      led_r        <= 1'b0;
    end else begin
      tick_count_r <= tick_count_nxt;
      tick_inc_r   <= tick_inc_nxt;
      next_step_r  <= next_step_nxt;
      led_on_r     <= led_on_nxt;
      led_off_r    <= led_off_nxt;
      led_r        <= led_nxt;
    end
  end

  // Channel control
  always_comb begin
    chan_ctl.tick      = is_tick;
    chan_ctl.step_hit  = step_hit;
    chan_ctl.hold      = s1_hold_r;
    chan_ctl.load      = is_load && ({2'b00, s1_channel_r} < 5'(CHANNELS));
    chan_ctl.load_chan = s1_channel_r;
    chan_ctl.load_pw   = pw_sat;
    chan_ctl.tick_n    = tick_n;
  end

  logic [NCH-1:0]        active_nxt;
  logic [DTS_MASK_W-1:0] trig;

  for (genvar ch = 0; ch < NCH; ch++) begin : g_chan
    dts_channel #(
      .CH_IDX        (ch),
      .HIHAT_CHANNEL (HIHAT_CHANNEL)
    ) u_chan (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (chan_ctl),
      .fire_bit   (s1_mask_r[ch]),
      .active_nxt (active_nxt[ch])
    );
  end

  always_comb begin
    trig          = '0;
    trig[NCH-1:0] = active_nxt;
  end

  // Strobe dividers
  logic poll_due;
  logic refresh_due;

  dts_divider u_poll (
    .clk    (clk),
    .rst_n  (rst_n),
    .tick   (is_tick),
    .period (poll_period_r),
    .due    (poll_due)
  );

  dts_divider u_refresh (
    .clk    (clk),
    .rst_n  (rst_n),
    .tick   (is_tick),
    .period (refresh_period_r),
    .due    (refresh_due)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (go) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_data_r <= {4'b0000, tick_count_nxt, refresh_due, poll_due, step_hit, led_nxt, trig};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

// File: hw/rtl/dts_divider.sv
`default_nettype none

module dts_divider
  import dts_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 tick,
  input  wire logic [DTS_DIV_W-1:0] period,
  output logic                      due
);

  logic [DTS_DIV_W-1:0] div_r;
  logic [DTS_DIV_W-1:0] div_nxt;
  logic [DTS_DIV_W-1:0] inc;

  // Count ticks, wrap to zero once the period is reached
  always_comb begin
    inc     = div_r + 1'b1;
    due     = 1'b0;
    div_nxt = div_r;
    if (tick) begin
      due     = (inc >= period);
      div_nxt = due ? '0 : inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_r <= '0;
    end else begin
      div_r <= div_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/dts_channel.sv
`default_nettype none

module dts_channel
  import dts_pkg::*;
#(
  parameter int CH_IDX        = 0,
  parameter int HIHAT_CHANNEL = DTS_HIHAT_CHANNEL
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire dts_chan_ctl_t ctl,
  input  wire logic          fire_bit,
  output logic               active_nxt
);

  localparam logic IS_HIHAT = (CH_IDX == HIHAT_CHANNEL);

  logic                  active_r;
  logic [DTS_PW_W-1:0]   pw_r;
  logic [DTS_PW_W-1:0]   pw_nxt;
  logic [DTS_TIME_W-1:0] rel_r;
  logic [DTS_TIME_W-1:0] rel_nxt;
  logic [DTS_TIME_W:0]   rel_sum;
  logic                  due;

  always_comb begin
    pw_nxt     = pw_r;
    rel_nxt    = rel_r;
    active_nxt = active_r;
    due        = 1'b0;
    rel_sum    = {1'b0, ctl.tick_n} + {{(DTS_TIME_W + 1 - DTS_PW_W){1'b0}}, pw_r};

    // Take a new pulse width for this channel
    if (ctl.load && (ctl.load_chan == DTS_CHAN_W'(CH_IDX))) begin
      pw_nxt = ctl.load_pw;
    end

    if (ctl.tick) begin
      // Assert on a step; the new release time is due now only if it wrapped or the pulse width is zero
      if (ctl.step_hit && fire_bit) begin
        active_nxt = 1'b1;
        rel_nxt    = rel_sum[DTS_TIME_W-1:0];
        due        = rel_sum[DTS_TIME_W] || (pw_r == '0);
      end else begin
        due = (ctl.tick_n >= rel_r);
      end
      // Drop the trigger once due, unless this is the held hi-hat
      if (active_nxt && due && !(IS_HIHAT && ctl.hold)) begin
        active_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      pw_r     <= '0;
      rel_r    <= '0;
    end else begin
      active_r <= active_nxt;
      pw_r     <= pw_nxt;
      rel_r    <= rel_nxt;
    end
  end

endmodule

`default_nettype wire
